// File: src/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ACM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition never holds outside reset.
`define ACM_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: src/acm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_pkg
// Types and constants for the stereo capture converter and level meter.
// ----------------------------------------------------------------------------
package acm_pkg;

    localparam int MAX_FRAMES   = 4096;
    localparam int MAX_CHANNELS = 8;
    localparam int FCNT_W       = $clog2(MAX_FRAMES + 1);
    localparam int POS_W        = 3;
    localparam int SUM_W        = 44;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);

    localparam logic [16:0] KEEP_WEIGHT = 17'd55706;
    localparam logic [13:0] NEW_WEIGHT  = 14'd9830;

    localparam logic [1:0] FMT_INT16 = 2'd0;
    localparam logic [1:0] FMT_INT24 = 2'd1;
    localparam logic [1:0] FMT_INT32 = 2'd2;
    localparam logic [1:0] FMT_FLOAT = 2'd3;

    localparam logic [0:0] REG_CHANNEL_COUNT = 1'd0;
    localparam logic [0:0] REG_SAMPLE_FORMAT = 1'd1;

    typedef struct packed {
        logic [31:0] sample_word;
        logic        packet_end;
        logic        silent;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] left_sample;
        logic signed [31:0] right_sample;
        logic        [30:0] level_left;
        logic        [30:0] level_right;
        logic               packet_last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
        logic        last;
    } t_frame;

endpackage

// File: src/acm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_front
// Converts each sample to Q1.31, tracks the channel position and builds
// one stereo frame record per completed frame.
// ----------------------------------------------------------------------------
module acm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  acm_pkg::t_in_item i_item,
    input  logic [3:0]        i_channel_count,
    input  logic [1:0]        i_sample_format,
    output logic              o_push,
    output acm_pkg::t_frame   o_frame
);

    logic [acm_pkg::POS_W-1:0] r_pos;
    logic [31:0]               r_left;
    logic [31:0]               r_right;

    logic [3:0]  n_ch;
    logic [31:0] conv;
    logic [31:0] s;
    logic        done;
    logic [31:0] l_new;
    logic [31:0] r_new;

    // Float to Q1.31, truncating toward zero.
    function automatic logic [31:0] float_q31(input logic [31:0] w);
        logic        neg;
        logic [7:0]  e;
        logic [22:0] f;
        logic [23:0] mant;
        logic [7:0]  sh;
        logic [31:0] mag;
        neg  = w[31];
        e    = w[30:23];
        f    = w[22:0];
        mant = {1'b1, f};
        mag  = '0;
        if (e == 8'd255 && f != '0) begin
            return '0;
        end
        if (e >= 8'd127) begin
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        if (e == 8'd0) begin
            return '0;
        end
        if (e >= 8'd119) begin
            sh  = e - 8'd119;
            mag = {8'd0, mant} << sh[2:0];
        end else begin
            sh  = 8'd119 - e;
            mag = (sh >= 8'd32) ? '0 : ({8'd0, mant} >> sh[4:0]);
        end
        return neg ? (32'd0 - mag) : mag;
    endfunction

    always_comb begin
        if (i_channel_count == 4'd0) begin
            n_ch = 4'd1;
        end else if (i_channel_count > 4'(acm_pkg::MAX_CHANNELS)) begin
            n_ch = 4'(acm_pkg::MAX_CHANNELS);
        end else begin
            n_ch = i_channel_count;
        end
    end

    always_comb begin
        unique case (i_sample_format)
            acm_pkg::FMT_INT16: conv = {i_item.sample_word[15:0], 16'd0};
            acm_pkg::FMT_INT24: conv = {i_item.sample_word[23:0], 8'd0};
            acm_pkg::FMT_INT32: conv = i_item.sample_word;
            acm_pkg::FMT_FLOAT: conv = float_q31(i_item.sample_word);
            default:            conv = '0;
        endcase
    end

    assign s     = i_item.silent ? '0 : conv;
    assign done  = ({1'b0, r_pos} + 4'd1) >= n_ch;
    assign l_new = (r_pos == '0) ? s : r_left;
    assign r_new = (n_ch == 4'd1) ? l_new : ((r_pos == 3'd1) ? s : r_right);

    assign o_push  = i_accept && done;
    assign o_frame = '{left: l_new, right: r_new, last: i_item.packet_end};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_left  <= '0;
            r_right <= '0;
        end else if (i_accept) begin
            if (r_pos == '0) begin
                r_left <= s;
            end
            if (r_pos == 3'd1) begin
                r_right <= s;
            end
            r_pos <= done ? '0 : r_pos + 3'd1;
        end
    end

endmodule

// File: src/acm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_queue
// Short frame queue between the converter and the level meter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  acm_pkg::t_frame i_data,
    input  logic            i_pop,
    output acm_pkg::t_frame o_data,
    output logic            o_full,
    output logic            o_empty
);

    acm_pkg::t_frame                r_mem [acm_pkg::QDEPTH];
    logic [acm_pkg::QPTR_W-1:0]     r_wr;
    logic [acm_pkg::QPTR_W-1:0]     r_rd;
    logic [acm_pkg::QPTR_W:0]       r_cnt;

    assign o_full  = (r_cnt == (acm_pkg::QPTR_W + 1)'(acm_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (acm_pkg::QPTR_W + 1)'(i_push)
                           - (acm_pkg::QPTR_W + 1)'(i_pop);
        end
    end

    `ACM_NEVER(a_no_push_full, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `ACM_NEVER(a_no_pop_empty, i_clk, i_rst_n, i_pop && o_empty, "pop from empty queue")

endmodule

// File: src/acm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_back
// Sums squares per frame; at packet end divides, takes the root and
// smooths each channel level in turn with one shared divider and root unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  acm_pkg::t_frame    i_q_data,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output acm_pkg::t_out_item o_item
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ACC    = 3'd1;
    localparam logic [2:0] ST_DINIT  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_SQINIT = 3'd4;
    localparam logic [2:0] ST_SQRT   = 3'd5;
    localparam logic [2:0] ST_SMUL   = 3'd6;
    localparam logic [2:0] ST_SADD   = 3'd7;

    localparam int FW = acm_pkg::FCNT_W;
    localparam int SW = acm_pkg::SUM_W;

    logic [2:0]          r_state;
    logic                r_side;
    logic [31:0]         r_l;
    logic [31:0]         r_r;
    logic                r_last;
    logic [31:0]         r_sq_l;
    logic [31:0]         r_sq_r;
    logic [SW-1:0]       r_sum_l;
    logic [SW-1:0]       r_sum_r;
    logic [FW-1:0]       r_fcnt;
    logic [30:0]         r_sm_l;
    logic [30:0]         r_sm_r;
    logic [SW-1:0]       r_quo;
    logic [FW-1:0]       r_rem;
    logic [5:0]          r_step;
    logic [63:0]         r_rad;
    logic [33:0]         r_srem;
    logic [31:0]         r_root;
    logic [47:0]         r_pa;
    logic [44:0]         r_pb;
    logic                r_out_valid;
    acm_pkg::t_out_item  r_out;

    logic        out_free;
    logic [31:0] mag_l;
    logic [31:0] mag_r;
    logic [FW:0] rem_sh;
    logic        div_ge;
    logic [FW:0] rem_sub;
    logic [SW-1:0] mean;
    logic [35:0] sq_t;
    logic [35:0] sq_trial;
    logic        sq_ge;
    logic [35:0] sq_sub;
    logic [30:0] rms;
    logic [48:0] smooth_sum;
    logic [30:0] sm_new;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == ST_IDLE) && !i_q_empty && out_free;
    assign o_valid  = r_out_valid;
    assign o_item   = r_out;

    assign mag_l = i_q_data.left[31]  ? (32'd0 - i_q_data.left)  : i_q_data.left;
    assign mag_r = i_q_data.right[31] ? (32'd0 - i_q_data.right) : i_q_data.right;

    // Restoring divide, one quotient bit a cycle.
    assign rem_sh  = {r_rem, r_quo[SW-1]};
    assign div_ge  = rem_sh >= {1'b0, r_fcnt};
    assign rem_sub = rem_sh - {1'b0, r_fcnt};

    always_comb begin
        if (r_fcnt == '0) begin
            mean = '0;
        end else if (r_quo > SW'(64'h3F_FFFF_FFFF)) begin
            mean = SW'(64'h3F_FFFF_FFFF);
        end else begin
            mean = r_quo;
        end
    end

    // Digit-by-digit root, one result bit a cycle.
    assign sq_t     = {r_srem, r_rad[63:62]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;
    assign sq_sub   = sq_t - sq_trial;

    assign rms        = r_root[31] ? 31'h7FFF_FFFF : r_root[30:0];
    assign smooth_sum = {1'b0, r_pa} + {4'd0, r_pb} + 49'd32768;
    assign sm_new     = smooth_sum[46:16];

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_l    <= i_q_data.left;
            r_r    <= i_q_data.right;
            r_last <= i_q_data.last;
            r_sq_l <= mag_l[31:16] * mag_l[31:16];
            r_sq_r <= mag_r[31:16] * mag_r[31:16];
        end
        unique case (r_state)
            ST_DINIT: begin
                r_quo  <= r_side ? r_sum_r : r_sum_l;
                r_rem  <= '0;
                r_step <= '0;
            end
            ST_DIV: begin
                r_quo <= {r_quo[SW-2:0], div_ge};
                r_rem <= div_ge ? rem_sub[FW-1:0] : rem_sh[FW-1:0];
                r_step <= r_step + 6'd1;
            end
            ST_SQINIT: begin
                r_rad  <= {mean[31:0], 32'd0};
                r_srem <= '0;
                r_root <= '0;
                r_step <= '0;
            end
            ST_SQRT: begin
                r_rad  <= {r_rad[61:0], 2'b00};
                r_srem <= sq_ge ? sq_sub[33:0] : sq_t[33:0];
                r_root <= {r_root[30:0], sq_ge};
                r_step <= r_step + 6'd1;
            end
            ST_SMUL: begin
                r_pa <= (r_side ? r_sm_r : r_sm_l) * acm_pkg::KEEP_WEIGHT;
                r_pb <= rms * acm_pkg::NEW_WEIGHT;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_side      <= 1'b0;
            r_sum_l     <= '0;
            r_sum_r     <= '0;
            r_fcnt      <= '0;
            r_sm_l      <= '0;
            r_sm_r      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (r_fcnt < FW'(acm_pkg::MAX_FRAMES)) begin
                        r_fcnt  <= r_fcnt + 1'b1;
                        r_sum_l <= r_sum_l + SW'(r_sq_l);
                        r_sum_r <= r_sum_r + SW'(r_sq_r);
                    end
                    if (r_last) begin
                        r_side  <= 1'b0;
                        r_state <= ST_DINIT;
                    end else begin
                        r_out       <= '{r_l, r_r, r_sm_l, r_sm_r, 1'b0};
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_DINIT: r_state <= ST_DIV;
                ST_DIV: begin
                    if (r_step == 6'(SW - 1)) begin
                        r_state <= ST_SQINIT;
                    end
                end
                ST_SQINIT: r_state <= ST_SQRT;
                ST_SQRT: begin
                    if (r_step == 6'd31) begin
                        r_state <= ST_SMUL;
                    end
                end
                ST_SMUL: r_state <= ST_SADD;
                ST_SADD: begin
                    if (!r_side) begin
                        r_sm_l  <= sm_new;
                        r_side  <= 1'b1;
                        r_state <= ST_DINIT;
                    end else begin
                        r_sm_r      <= sm_new;
                        r_sum_l     <= '0;
                        r_sum_r     <= '0;
                        r_fcnt      <= '0;
                        r_out       <= '{r_l, r_r, r_sm_l, sm_new, 1'b1};
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `ACM_ASSERT(a_fcnt_cap, i_clk, i_rst_n, r_fcnt <= FW'(acm_pkg::MAX_FRAMES), "frame count over cap")
    `ACM_ASSERT(a_out_free_on_pop, i_clk, i_rst_n, o_pop |=> !r_out_valid, "result slot busy after pop")

endmodule

// File: src/audio_capture_stereo_level_meter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_capture_stereo_level_meter_core
// Converts interleaved captured samples to stereo Q1.31 pairs and keeps a
// smoothed RMS level per output channel.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  in        i_in_valid / o_in_stall   i_in_item  (t_in_item)
//  out       o_out_valid / i_out_stall o_out_item (t_out_item)
//  config    i_cfg_we                  i_cfg_idx, i_cfg_data
//
//  Samples are taken one a cycle while the four-entry frame queue has room.
//  A plain frame is popped from the queue head, registered and summed, and its
//  result registered; a packet-closing frame first runs the shared 44-step
//  divider and 32-step root unit once for each channel.
//  Synchronous active-low reset clears control state only; no clearing pass.
//  A stalled output holds its result; the queue absorbs input meanwhile.
// ----------------------------------------------------------------------------
module audio_capture_stereo_level_meter_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  acm_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output acm_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [3:0]         i_cfg_data
);

    logic [3:0]      r_channel_count;
    logic [1:0]      r_sample_format;
    logic            accept;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    acm_pkg::t_frame frame_in;
    acm_pkg::t_frame frame_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= 4'd2;
            r_sample_format <= acm_pkg::FMT_INT16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                acm_pkg::REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data;
                acm_pkg::REG_SAMPLE_FORMAT: r_sample_format <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    acm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_item          (i_in_item),
        .i_channel_count (r_channel_count),
        .i_sample_format (r_sample_format),
        .o_push          (push),
        .o_frame         (frame_in)
    );

    acm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (frame_in),
        .i_pop   (pop),
        .o_data  (frame_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    acm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (frame_out),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_item    (o_out_item)
    );

endmodule
